[src/sshec_pkg.sv]
package sshec_pkg;

	// Sizes of the sensor array and its state.
	localparam int NUM_SLOTS = 6;
	localparam int NUM_LINES = 2 * NUM_SLOTS;
	localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Fixed field widths of the stream payloads.
	localparam int SENSOR_W     = 12;
	localparam int SLOT_FIELD_W = 3;
	localparam int HOLD_W       = 8;
	localparam int CNT_W        = 16;
	localparam int VALUE_W      = 8;
	localparam int IN_DATA_W    = 24;
	localparam int IN_USER_W    = 1;
	localparam int OUT_DATA_W   = 40;
	localparam int OUT_USER_W   = 2;

	localparam logic [HOLD_W-1:0] HOLD_MAX   = 8'd255;
	localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd254;

	// Request kinds on the input stream.
	typedef enum logic {
		KIND_TICK = 1'b0,
		KIND_SET  = 1'b1
	} kind_t;

	// Event codes on the output stream.
	typedef enum logic [1:0] {
		EV_DISP_REP    = 2'd0,
		EV_DISP_OFF    = 2'd1,
		EV_EMPTY_REP   = 2'd2,
		EV_EMPTY_UNREP = 2'd3
	} event_res_t;

	// One word of the per-slot count memory.
	typedef struct packed {
		logic [CNT_W-1:0] offline;
		logic [CNT_W-1:0] stock;
	} cnt_t;

	// One outgoing event.
	typedef struct packed {
		event_res_t              res;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [CNT_W-1:0]        stock;
		logic [CNT_W-1:0]        offline;
		logic                    last;
	} event_t;

endpackage

[src/slot_sensor_hold_event_counter.sv]
// A tick request sweeps the twelve hold counters through the hold memory, one line per cycle
// while the output does not stall, and the block takes no new request until all lines are issued;
// a set request does not keep the block busy. An event is held until the next event or the end
// of the sweep settles its last flag. Reset (arst_n low, asynchronous) clears control state and
// memory valid bits, so all counters read zero; threshold is 254.
module slot_sensor_hold_event_counter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// sensor_lines[11:0], link_up[12], slot[15:13], value[23:16]
	input  logic [sshec_pkg::IN_DATA_W-1:0]  s_tdata,
	// kind[0]
	input  logic [sshec_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// event_slot[2:0], stock_count[18:3], offline_count[34:19], zero[39:35]
	output logic [sshec_pkg::OUT_DATA_W-1:0] m_tdata,
	// event_res[1:0]
	output logic [sshec_pkg::OUT_USER_W-1:0] m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sshec_pkg::HOLD_W-1:0]     cfg_data
);
	import sshec_pkg::*;

	localparam logic [LINE_W-1:0] LAST_LINE  = LINE_W'(NUM_LINES - 1);
	localparam logic [LINE_W-1:0] FIRST_EMPTY = LINE_W'(NUM_SLOTS);

	// Input fields.
	kind_t                   in_kind;
	logic [SENSOR_W-1:0]     in_lines;
	logic                    in_link;
	logic [SLOT_FIELD_W-1:0] in_slot;
	logic [VALUE_W-1:0]      in_value;
	logic [NUM_LINES-1:0]    in_lines_ext;
	logic                    in_range;

	assign in_kind      = kind_t'(s_tuser[0]);
	assign in_lines     = s_tdata[11:0];
	assign in_link      = s_tdata[12];
	assign in_slot      = s_tdata[15:13];
	assign in_value     = s_tdata[23:16];
	assign in_lines_ext = NUM_LINES'(in_lines);
	assign in_range     = int'(in_slot) < NUM_SLOTS;

	// Threshold register.
	logic [HOLD_W-1:0] thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Memories and their valid bits.
	logic [HOLD_W-1:0]    hold_mem [NUM_LINES];
	cnt_t                 cnt_mem  [NUM_SLOTS];
	logic [NUM_LINES-1:0] hold_vld_q;
	logic [NUM_SLOTS-1:0] cnt_vld_q;

	// Sweep state of the issue stage.
	logic                 busy_q;
	logic [LINE_W-1:0]    line_q;
	logic [NUM_LINES-1:0] lines_q;
	logic                 link_q;

	// Stage 1 registers.
	logic              v_s1;
	kind_t             op_s1;
	logic [LINE_W-1:0] line_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              high_s1;
	logic              link_s1;
	logic              range_s1;
	logic [VALUE_W-1:0] value_s1;

	// Registered read data and count forwarding.
	logic [HOLD_W-1:0] hold_rd_q;
	logic              hold_rd_vld_q;
	cnt_t              cnt_rd_q;
	logic              cnt_rd_vld_q;
	logic              cnt_fwd_q;
	cnt_t              cnt_fwd_data_q;

	// Pending event and output register.
	logic   pend_v_q;
	event_t pend_q;
	logic   out_v_q;
	event_t out_q;

	// Handshake and stall control.
	logic advance;
	logic s1_done;
	logic s1_evt;
	logic s1_evt_go;
	logic out_free;
	logic pend_move;
	logic accept;

	// Issue stage signals.
	logic              iss_v;
	kind_t             iss_op;
	logic [LINE_W-1:0] iss_line;
	logic [SLOT_W-1:0] iss_slot;
	logic              iss_high;
	logic              iss_link;
	logic              iss_range;
	logic              rd_en;

	// Stage 1 computation.
	logic [HOLD_W-1:0]  hold_old;
	logic [HOLD_W-1:0]  hold_nxt;
	logic               fired;
	logic               is_disp;
	cnt_t               cnt_old;
	cnt_t               cnt_new;
	event_res_t         ev_res;
	logic               hold_we;
	logic               cnt_we;
	event_t             ev_new;

	// Stall chain from the output backwards.
	assign out_free  = !out_v_q || m_tready;
	assign s1_evt    = v_s1 && (op_s1 == KIND_TICK) && fired;
	assign s1_done   = !s1_evt || !pend_v_q || out_free;
	assign s1_evt_go = s1_evt && s1_done;
	assign advance   = !v_s1 || s1_done;
	assign s_tready  = advance && !busy_q;
	assign accept    = s_tvalid && s_tready;
	assign pend_move = pend_v_q && out_free && (pend_q.last || s1_evt_go);

	// The sweep has priority; a new request enters once the previous tick has issued all lines.
	always_comb begin
		iss_v     = busy_q || s_tvalid;
		iss_op    = KIND_TICK;
		iss_line  = line_q;
		iss_high  = lines_q[line_q];
		iss_link  = link_q;
		iss_range = 1'b1;
		if (!busy_q) begin
			iss_op    = in_kind;
			iss_line  = '0;
			iss_high  = in_lines_ext[0];
			iss_link  = in_link;
			iss_range = in_range;
		end
		if (iss_op == KIND_SET) begin
			iss_slot = in_range ? SLOT_W'(in_slot) : '0;
		end else if (iss_line < FIRST_EMPTY) begin
			iss_slot = SLOT_W'(iss_line);
		end else begin
			iss_slot = SLOT_W'(iss_line - FIRST_EMPTY);
		end
	end

	assign rd_en = advance && iss_v;

	// Sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			line_q <= '0;
		end else if (advance) begin
			if (busy_q) begin
				if (line_q == LAST_LINE) begin
					busy_q <= 1'b0;
				end else begin
					line_q <= line_q + LINE_W'(1);
				end
			end else if (accept && (in_kind == KIND_TICK) && (NUM_LINES > 1)) begin
				busy_q <= 1'b1;
				line_q <= LINE_W'(1);
			end
		end
	end

	// Sensor sample and link state held for the sweep.
	always_ff @(posedge clk) begin
		if (accept && (in_kind == KIND_TICK)) begin
			lines_q <= in_lines_ext;
			link_q  <= in_link;
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= iss_v;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			op_s1    <= iss_op;
			line_s1  <= iss_line;
			slot_s1  <= iss_slot;
			high_s1  <= iss_high;
			link_s1  <= iss_link;
			range_s1 <= iss_range;
			value_s1 <= in_value;
		end
	end

	// Hold counter update and event detection.
	always_comb begin
		hold_old = hold_rd_vld_q ? hold_rd_q : '0;
		if (!high_s1) begin
			hold_nxt = '0;
		end else if (hold_old == HOLD_MAX) begin
			hold_nxt = hold_old;
		end else begin
			hold_nxt = hold_old + HOLD_W'(1);
		end
		fired = (hold_nxt != hold_old) && (hold_nxt == thr_q);
	end

	// Slot count update.
	always_comb begin
		if (cnt_fwd_q) begin
			cnt_old = cnt_fwd_data_q;
		end else if (cnt_rd_vld_q) begin
			cnt_old = cnt_rd_q;
		end else begin
			cnt_old = '0;
		end
		is_disp = line_s1 < FIRST_EMPTY;
		cnt_new = cnt_old;
		ev_res  = EV_DISP_REP;
		if (op_s1 == KIND_SET) begin
			cnt_new.stock = CNT_W'(value_s1);
		end else if (is_disp) begin
			if (cnt_old.stock != '0) begin
				cnt_new.stock = cnt_old.stock - CNT_W'(1);
			end
			if (!link_s1) begin
				cnt_new.offline = cnt_old.offline + CNT_W'(1);
			end
			ev_res = link_s1 ? EV_DISP_REP : EV_DISP_OFF;
		end else begin
			cnt_new.stock = '0;
			ev_res = link_s1 ? EV_EMPTY_REP : EV_EMPTY_UNREP;
		end
		hold_we = v_s1 && s1_done && (op_s1 == KIND_TICK);
		cnt_we  = v_s1 && s1_done &&
			(((op_s1 == KIND_TICK) && fired) || ((op_s1 == KIND_SET) && range_s1));
		ev_new.res     = ev_res;
		ev_new.slot    = SLOT_FIELD_W'(slot_s1);
		ev_new.stock   = cnt_new.stock;
		ev_new.offline = cnt_new.offline;
		ev_new.last    = (line_s1 == LAST_LINE);
	end

	// Memory ports: one read and one write each per cycle.
	always_ff @(posedge clk) begin
		if (hold_we) begin
			hold_mem[line_s1] <= hold_nxt;
		end
		if (cnt_we) begin
			cnt_mem[slot_s1] <= cnt_new;
		end
		if (rd_en) begin
			hold_rd_q      <= hold_mem[iss_line];
			cnt_rd_q       <= cnt_mem[iss_slot];
			cnt_fwd_data_q <= cnt_new;
		end
	end

	// Valid bits, read valid and forwarding of a count written while the same slot is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q    <= '0;
			cnt_vld_q     <= '0;
			hold_rd_vld_q <= 1'b0;
			cnt_rd_vld_q  <= 1'b0;
			cnt_fwd_q     <= 1'b0;
		end else begin
			if (hold_we) begin
				hold_vld_q[line_s1] <= 1'b1;
			end
			if (cnt_we) begin
				cnt_vld_q[slot_s1] <= 1'b1;
			end
			if (rd_en) begin
				hold_rd_vld_q <= hold_vld_q[iss_line];
				cnt_rd_vld_q  <= cnt_vld_q[iss_slot];
				cnt_fwd_q     <= cnt_we && (slot_s1 == iss_slot);
			end
		end
	end

	// The pending event waits until the next event or the end of the sweep tells its last flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (s1_evt_go) begin
				pend_v_q <= 1'b1;
			end else if (pend_move) begin
				pend_v_q <= 1'b0;
			end
			if (pend_move) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Pending and output payload; a stalled event on the last line is not a sweep end.
	always_ff @(posedge clk) begin
		if (s1_evt_go) begin
			pend_q <= ev_new;
		end else if (v_s1 && (op_s1 == KIND_TICK) && (line_s1 == LAST_LINE) && !s1_evt &&
				!pend_move) begin
			pend_q.last <= 1'b1;
		end
		if (pend_move) begin
			out_q <= pend_q;
		end
	end

	// Output stream.
	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'b0, out_q.offline, out_q.stock, out_q.slot};
	assign m_tuser  = out_q.res;
	assign m_tlast  = out_q.last;

endmodule

[src/sshec_checker.sv]
module sshec_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [sshec_pkg::IN_USER_W-1:0]  s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [sshec_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [sshec_pkg::OUT_USER_W-1:0] m_tuser,
	input logic                             m_tlast,
	input logic                             cfg_valid,
	input logic                             cfg_ready
);
	import sshec_pkg::*;

	// A stalled event holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output event changed");

	// A tick request keeps the block busy for its sweep.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == KIND_TICK) |=> !s_tready)
		else $error("request accepted during a tick sweep");

	// An empty event always reports a cleared stock count.
	a_empty_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[18:3] == '0)
		else $error("empty event with non-zero stock count");

	// Every event names an existing slot.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> int'(m_tdata[2:0]) < NUM_SLOTS)
		else $error("event slot out of range");

	// The threshold register never back-pressures.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind slot_sensor_hold_event_counter sshec_checker u_sshec_checker (.*);
